/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the GPIO register block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: %m");

// Condition that must never be seen while out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition: %m");

`endif

/* rtl/gprpd_pkg.sv */
// ----------------------------------------------------------------------------
// gprpd_pkg
// Offsets, detector pattern and shared types for the GPIO register block.
// ----------------------------------------------------------------------------
package gprpd_pkg;

    localparam int ADDR_W  = 10;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 7;

    localparam int PATTERN_LEN = 92;
    localparam int WATCH_PIN   = 12;
    localparam int RESET_PIN   = WATCH_PIN + 16;

    // Leftmost bit is fed first.
    localparam logic [PATTERN_LEN-1:0] PATTERN =
        92'b10110110101100001100001100001010110000101101101101011011010000000100000000001011011011000010;

    // Register offsets
    localparam logic [ADDR_W-1:0] OFS_MODE  = 10'h000;
    localparam logic [ADDR_W-1:0] OFS_OTYPE = 10'h004;
    localparam logic [ADDR_W-1:0] OFS_SPEED = 10'h008;
    localparam logic [ADDR_W-1:0] OFS_PULL  = 10'h00C;
    localparam logic [ADDR_W-1:0] OFS_IDATA = 10'h010;
    localparam logic [ADDR_W-1:0] OFS_ODATA = 10'h014;
    localparam logic [ADDR_W-1:0] OFS_BSRR  = 10'h018;
    localparam logic [ADDR_W-1:0] OFS_LOCK  = 10'h01C;
    localparam logic [ADDR_W-1:0] OFS_AFL   = 10'h020;
    localparam logic [ADDR_W-1:0] OFS_AFH   = 10'h024;
    localparam logic [ADDR_W-1:0] OFS_BRR   = 10'h028;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Detector requests raised by one access; set goes before clear.
    typedef struct packed {
        logic set_req;
        logic clr_req;
    } feed_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             hit;
    } step_t;

    function automatic logic pat_bit(input logic [POS_W-1:0] pos);
        logic r;
        r = 1'b0;
        if (pos < POS_W'(PATTERN_LEN))
            r = PATTERN[POS_W'(PATTERN_LEN - 1) - pos];
        return r;
    endfunction

    // One detector step: naive restart, no overlap.
    function automatic step_t feed_step(input logic [POS_W-1:0] pos, input logic b);
        step_t s;
        s.pos = '0;
        s.hit = 1'b0;
        if (pos < POS_W'(PATTERN_LEN) && pat_bit(pos) == b) begin
            s.pos = pos + POS_W'(1);
            s.hit = (s.pos == POS_W'(PATTERN_LEN));
        end
        else begin
            s.pos = (b == pat_bit('0)) ? POS_W'(1) : '0;
        end
        return s;
    endfunction

endpackage

/* rtl/gprpd_regfile.sv */
// ----------------------------------------------------------------------------
// gprpd_regfile
// Port register words, address decode, read mux and detector requests.
// ----------------------------------------------------------------------------
module gprpd_regfile
    import gprpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              func,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] read_data,
    output logic              bad_address,
    output feed_t             feed
);

    logic [DATA_W-1:0] mode_reg;
    logic [DATA_W-1:0] otype_reg;
    logic [DATA_W-1:0] speed_reg;
    logic [DATA_W-1:0] pull_reg;
    logic [DATA_W-1:0] odata_reg;
    logic [DATA_W-1:0] lock_reg;
    logic [DATA_W-1:0] afr_reg [2];

    logic wr;

    assign wr = en && (func == FUNC_WRITE);

    always_comb
    begin
        read_data   = '0;
        bad_address = 1'b0;
        feed        = '0;
        if (func == FUNC_READ) begin
            case (addr)
                OFS_MODE:  read_data = mode_reg;
                OFS_OTYPE: read_data = otype_reg;
                OFS_SPEED: read_data = speed_reg;
                OFS_PULL:  read_data = pull_reg;
                OFS_IDATA: read_data = '0;
                OFS_ODATA: read_data = odata_reg;
                OFS_BSRR:  read_data = '0;
                OFS_LOCK:  read_data = lock_reg;
                OFS_AFL:   read_data = afr_reg[0];
                OFS_AFH:   read_data = afr_reg[1];
                OFS_BRR:   read_data = '0;
                default:   bad_address = 1'b1;
            endcase
        end
        else begin
            case (addr)
                OFS_MODE, OFS_OTYPE, OFS_SPEED, OFS_PULL, OFS_ODATA,
                OFS_LOCK, OFS_AFL, OFS_AFH: bad_address = 1'b0;
                OFS_BSRR:
                begin
                    feed.set_req = wdata[WATCH_PIN];
                    feed.clr_req = wdata[RESET_PIN];
                end
                OFS_BRR:   feed.clr_req = wdata[WATCH_PIN];
                default:   bad_address = 1'b1;   // includes input-data word
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= '0;
            otype_reg  <= '0;
            speed_reg  <= '0;
            pull_reg   <= '0;
            odata_reg  <= '0;
            lock_reg   <= '0;
            afr_reg[0] <= '0;
            afr_reg[1] <= '0;
        end
        else if (wr) begin
            case (addr)
                OFS_MODE:  mode_reg   <= wdata;
                OFS_OTYPE: otype_reg  <= wdata;
                OFS_SPEED: speed_reg  <= wdata;
                OFS_PULL:  pull_reg   <= wdata;
                OFS_ODATA: odata_reg  <= wdata;
                OFS_LOCK:  lock_reg   <= wdata;
                OFS_AFL:   afr_reg[0] <= wdata;
                OFS_AFH:   afr_reg[1] <= wdata;
                default:   ;
            endcase
        end
    end

endmodule

/* rtl/gprpd_seqdet.sv */
// ----------------------------------------------------------------------------
// gprpd_seqdet
// Pin sequence detector: up to two bits per access, set bit first.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gprpd_seqdet
    import gprpd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  feed_t feed,
    output logic  detected
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] pos_mid;
    step_t            s1;
    step_t            s2;
    logic             hit1;

    always_comb
    begin
        s1       = feed_step(pos_reg, 1'b1);
        pos_mid  = feed.set_req ? s1.pos : pos_reg;
        hit1     = feed.set_req && s1.hit;
        s2       = feed_step(pos_mid, 1'b0);
        pos_next = feed.clr_req ? s2.pos : pos_mid;
        detected = hit1 || (feed.clr_req && s2.hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (en)
            pos_reg <= pos_next;
    end

    `ASSERT_NEVER(a_pos_range, clk, rst_n, pos_reg > POS_W'(PATTERN_LEN))
    `ASSERT_CLK(a_hit_pos, clk, rst_n, (en && detected) |=> (pos_reg == POS_W'(PATTERN_LEN)))

endmodule

/* rtl/gpio_registers_with_pin_pattern_detector.sv */
// ----------------------------------------------------------------------------
// gpio_registers_with_pin_pattern_detector
// GPIO port register block with a 92-bit pin sequence detector.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)     | tuser (low bit up)
//  s_      | in  | addr[9:0], wdata[31:0] | func (0 read, 1 write)
//  m_      | out | read_data[31:0]        | detected, bad_address
//
//  One access per cycle sustained while m_tready is held high; each access
//  passes from accept through the input register, then decode/detector
//  logic into the result register.
//  Reset clears all register words, the detector position and both valids.
//  A stalled result holds the result register; the input register still
//  takes a word if the result moves on in the same cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gpio_registers_with_pin_pattern_detector
    import gprpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // addr[9:0], wdata[41:10], zero pad
    input  logic [0:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_data
    output logic [1:0]  m_tuser    // detected, bad_address
);

    // input register
    logic              in_valid_reg;
    logic              in_func_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic [DATA_W-1:0] in_wdata_reg;

    // result register
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_rdata_reg;
    logic              out_det_reg;
    logic              out_bad_reg;

    logic              advance;
    logic              take;
    logic [DATA_W-1:0] rdata;
    logic              bad;
    logic              det;
    feed_t             feed;

    // Item leaves the input register whenever the result slot is free
    // or being emptied this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    gprpd_regfile u_regfile (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .func        (in_func_reg),
        .addr        (in_addr_reg),
        .wdata       (in_wdata_reg),
        .read_data   (rdata),
        .bad_address (bad),
        .feed        (feed)
    );

    gprpd_seqdet u_seqdet (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .feed     (feed),
        .detected (det)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (take) begin
            in_func_reg  <= s_tuser[0];
            in_addr_reg  <= s_tdata[ADDR_W-1:0];
            in_wdata_reg <= s_tdata[ADDR_W +: DATA_W];
        end
        if (advance) begin
            out_rdata_reg <= rdata;
            out_det_reg   <= det;
            out_bad_reg   <= bad;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_rdata_reg;
    assign m_tuser  = {out_bad_reg, out_det_reg};

    `ASSERT_CLK(a_bad_reads_zero, clk, rst_n, (m_tvalid && m_tuser[1]) |-> (m_tdata == '0))
    `ASSERT_CLK(a_det_good_addr, clk, rst_n, (m_tvalid && m_tuser[0]) |-> !m_tuser[1])

endmodule
